FILE: hw/rtl/pnc_pkg.sv
// shared types and constants for the palette nearest color mapper
package pnc_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int DIST_W            = 10;
    localparam int RGB_W             = 24;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_MAP   = 2'd2,
        OP_RSVD  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_MAPPED    = 3'd0,
        ST_ADDED     = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RUN  = 2'd1,
        S_HOLD = 2'd2
    } t_state;

    // word travelling down the cell chain
    typedef struct packed {
        logic              live;
        t_op               op;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        alpha;
        logic              hit;
        logic [DIST_W-1:0] score;
        logic [RGB_W-1:0]  color;
    } t_tok;

    // palette write, broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [RGB_W-1:0] color;
    } t_wr;

endpackage

FILE: hw/rtl/pnc_cell.sv
// one palette cell: holds one entry and updates the passing word
module pnc_cell
    import pnc_pkg::*;
#(
    parameter int DEPTH = PALETTE_DEPTH_DEF,
    parameter int INDEX = 0,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tok             i_tok,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [CNT_W-1:0] i_count,
    input  t_wr              i_wr,
    input  logic [IDX_W-1:0] i_wr_idx,
    output t_tok             o_tok,
    output logic [IDX_W-1:0] o_idx
);

    logic [RGB_W-1:0]  r_color;
    t_tok              r_tok;
    logic [IDX_W-1:0]  r_idx;
    t_tok              n_tok;
    logic [IDX_W-1:0]  n_idx;
    logic              entry_ok;
    logic [DIST_W-1:0] entry_score;

    function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign entry_ok = i_count > CNT_W'(INDEX);
    assign entry_score = DIST_W'(absd(r_color[7:0], i_tok.red))
                       + DIST_W'(absd(r_color[15:8], i_tok.green))
                       + DIST_W'(absd(r_color[23:16], i_tok.blue));

    always_comb begin
        n_tok = i_tok;
        n_idx = i_idx;
        if (i_tok.live && entry_ok) begin
            // first matching entry wins for a duplicate check
            if (i_tok.op == OP_ADD && !i_tok.hit &&
                r_color == {i_tok.blue, i_tok.green, i_tok.red}) begin
                n_tok.hit   = 1'b1;
                n_tok.color = r_color;
                n_idx       = IDX_W'(INDEX);
            end
            // strict less keeps the earlier entry on a tie
            if (i_tok.op == OP_MAP && (!i_tok.hit || entry_score < i_tok.score)) begin
                n_tok.hit   = 1'b1;
                n_tok.score = entry_score;
                n_tok.color = r_color;
                n_idx       = IDX_W'(INDEX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr_idx == IDX_W'(INDEX)) begin
            r_color <= i_wr.color;
        end
        r_idx <= n_idx;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule

FILE: hw/rtl/palette_nearest_color_mapper.sv
// Palette nearest color mapper. Palette entries live in a chain of PALETTE_DEPTH cells; each
// accepted word walks the whole chain one cell per cycle, picking up the first exact match
// (add) or the entry with least |dr|+|dg|+|db| (map, ties to the earlier entry), and the
// result is settled when it leaves the last cell. One word is in the chain at a time, so the
// next word is not accepted until a clear, add or map has left the chain and its result has
// been handed to the output register. A finished result sits in the output register while
// the next word is taken. Op code 3 is accepted but gives no result.
module palette_nearest_color_mapper
    import pnc_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_alpha,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_status,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha,
    output logic [7:0] o_entry_index,
    output logic [9:0] o_distance
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    t_tok              tok [0:PALETTE_DEPTH];
    logic [IDX_W-1:0]  idx [0:PALETTE_DEPTH];
    t_wr               wr;
    logic [IDX_W-1:0]  wr_idx;
    logic              acc, inject, resolve, hand;
    t_tok              tok_end;
    logic [IDX_W-1:0]  idx_end;

    // pending result and output register
    t_status           r_p_status, n_p_status;
    logic [RGB_W-1:0]  r_p_rgb, n_p_rgb;
    logic [7:0]        r_p_alpha, n_p_alpha;
    logic [7:0]        r_p_index, n_p_index;
    logic [DIST_W-1:0] r_p_dist, n_p_dist;
    logic              r_o_valid;
    t_status           r_o_status;
    logic [RGB_W-1:0]  r_o_rgb;
    logic [7:0]        r_o_alpha;
    logic [7:0]        r_o_index;
    logic [DIST_W-1:0] r_o_dist;

    assign acc     = i_valid && o_ready;
    assign tok_end = tok[PALETTE_DEPTH];
    assign idx_end = idx[PALETTE_DEPTH];

    // word entering the first cell
    always_comb begin
        tok[0]       = '0;
        tok[0].live  = inject;
        tok[0].op    = t_op'(i_op);
        tok[0].red   = i_red;
        tok[0].green = i_green;
        tok[0].blue  = i_blue;
        tok[0].alpha = i_alpha;
        idx[0]       = '0;
    end

    for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
        pnc_cell #(
            .DEPTH (PALETTE_DEPTH),
            .INDEX (k),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (tok[k]),
            .i_idx    (idx[k]),
            .i_count  (r_count),
            .i_wr     (wr),
            .i_wr_idx (wr_idx),
            .o_tok    (tok[k+1]),
            .o_idx    (idx[k+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && t_op'(i_op) != OP_RSVD) n_state = S_RUN;
            end
            S_RUN: begin
                if (tok_end.live) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (!r_o_valid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        o_ready = 1'b0;
        inject  = 1'b0;
        resolve = 1'b0;
        hand    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                inject  = i_valid && t_op'(i_op) != OP_RSVD;
            end
            S_RUN:  resolve = tok_end.live;
            S_HOLD: hand    = !r_o_valid || i_ready;
            default: ;
        endcase
    end

    // settle the word leaving the chain
    always_comb begin
        n_count    = r_count;
        wr.en      = 1'b0;
        wr.color   = {tok_end.blue, tok_end.green, tok_end.red};
        wr_idx     = IDX_W'(r_count);
        n_p_status = ST_CLEARED;
        n_p_rgb    = '0;
        n_p_alpha  = '0;
        n_p_index  = '0;
        n_p_dist   = '0;
        unique case (tok_end.op)
            OP_ADD: begin
                n_p_rgb = {tok_end.blue, tok_end.green, tok_end.red};
                if (tok_end.hit) begin
                    n_p_status = ST_DUPLICATE;
                    n_p_index  = 8'(idx_end);
                end else if (r_count == CNT_W'(PALETTE_DEPTH)) begin
                    n_p_status = ST_FULL;
                end else begin
                    n_p_status = ST_ADDED;
                    n_p_index  = 8'(r_count);
                    wr.en      = resolve;
                    if (resolve) n_count = r_count + 1'b1;
                end
            end
            OP_MAP: begin
                n_p_alpha = tok_end.alpha;
                if (tok_end.hit) begin
                    n_p_status = ST_MAPPED;
                    n_p_rgb    = tok_end.color;
                    n_p_index  = 8'(idx_end);
                    n_p_dist   = tok_end.score;
                end else begin
                    n_p_status = ST_EMPTY;
                    n_p_rgb    = {tok_end.blue, tok_end.green, tok_end.red};
                end
            end
            default: begin
                if (resolve) n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (hand) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (resolve) begin
            r_p_status <= n_p_status;
            r_p_rgb    <= n_p_rgb;
            r_p_alpha  <= n_p_alpha;
            r_p_index  <= n_p_index;
            r_p_dist   <= n_p_dist;
        end
        if (hand) begin
            r_o_status <= r_p_status;
            r_o_rgb    <= r_p_rgb;
            r_o_alpha  <= r_p_alpha;
            r_o_index  <= r_p_index;
            r_o_dist   <= r_p_dist;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_out_red     = r_o_rgb[7:0];
    assign o_out_green   = r_o_rgb[15:8];
    assign o_out_blue    = r_o_rgb[23:16];
    assign o_out_alpha   = r_o_alpha;
    assign o_entry_index = r_o_index;
    assign o_distance    = r_o_dist;

    // no word may leave the chain unless one was taken in
    a_idle_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_RUN |-> !tok_end.live)
        else $error("word left chain outside run state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PALETTE_DEPTH))
        else $error("palette count above depth");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && t_op'(i_op) != OP_RSVD) |=> r_state == S_RUN)
        else $error("accepted word did not start a run");

    a_hand_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hand |=> o_valid)
        else $error("result handed over without output valid");

endmodule
